/* rtl/csrs3d_pkg.sv */
// shared types, constants and helper functions of the strain-rate stencil
package csrs3d_pkg;

    // grid limits and fixed-point format
    localparam int MAX_CELLS_X = 128;
    localparam int MAX_CELLS_Y = 128;
    localparam int FRAC_BITS   = 12;
    localparam int OFFDIAG_SHIFT = 3;   // four spacings and one half: divide by eight
    localparam int MIN_DIM     = 3;

    // field widths
    localparam int VEL_W   = 24;
    localparam int INV_W   = 24;
    localparam int OUT_W   = 32;
    localparam int CXR_W   = 8;
    localparam int CZR_W   = 16;
    localparam int CFG_W   = 24;
    localparam int IDX_COL_W   = 7;
    localparam int IDX_ROW_W   = 7;
    localparam int IDX_PLANE_W = 16;

    // position and store geometry
    localparam int COL_W  = $clog2(MAX_CELLS_X);
    localparam int ROW_W  = $clog2(MAX_CELLS_Y);
    localparam int DIMX_W = $clog2(MAX_CELLS_X + 1);
    localparam int DIMY_W = $clog2(MAX_CELLS_Y + 1);
    localparam int PLANE_CELLS = MAX_CELLS_X * MAX_CELLS_Y;
    localparam int STORE_DEPTH = 3 * PLANE_CELLS;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // read ports: three velocity components, ten reads each, two per memory
    localparam int N_COMP = 3;
    localparam int N_RD   = 10;
    localparam int N_PAIR = N_RD / 2;

    // datapath widths
    localparam int SUM_W  = VEL_W + 2;
    localparam int MUL_W  = INV_W + 1;
    localparam int PROD_W = SUM_W + MUL_W;
    localparam int RND_W  = PROD_W + 2;
    localparam int N_TERM = 9;

    typedef enum logic [2:0] {
        CFG_INV_X   = 3'd0,
        CFG_INV_Y   = 3'd1,
        CFG_INV_Z   = 3'd2,
        CFG_CELLS_X = 3'd3,
        CFG_CELLS_Y = 3'd4,
        CFG_CELLS_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic                                       hit;
        logic [ADDR_W-1:0]                          wr_addr;
        logic [N_COMP-1:0][N_RD-1:0][ADDR_W-1:0]    rd_addr;
        logic [IDX_COL_W-1:0]                       col;
        logic [IDX_ROW_W-1:0]                       row;
        logic [IDX_PLANE_W-1:0]                     plane;
    } t_scan;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_pipe_en;

    // first declared field sits in the highest bits: cell_plane on top, strain_xx lowest
    typedef struct packed {
        logic [IDX_PLANE_W-1:0] cell_plane;
        logic [IDX_ROW_W-1:0]   cell_row;
        logic [IDX_COL_W-1:0]   cell_col;
        logic [OUT_W-1:0]       strain_xy;
        logic [OUT_W-1:0]       strain_xz;
        logic [OUT_W-1:0]       strain_yz;
        logic [OUT_W-1:0]       strain_zz;
        logic [OUT_W-1:0]       strain_yy;
        logic [OUT_W-1:0]       strain_xx;
    } t_result;

    function automatic logic [ADDR_W-1:0] store_addr(input logic [1:0] slot,
                                                     input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        return ADDR_W'(32'(slot) * PLANE_CELLS + 32'(row) * MAX_CELLS_X + 32'(col));
    endfunction

    function automatic logic signed [SUM_W-1:0] sx(input logic [VEL_W-1:0] v);
        return SUM_W'(signed'(v));
    endfunction

    // round to nearest with ties up after dropping s bits, then saturate
    function automatic logic [OUT_W-1:0] round_sat(input logic signed [RND_W-1:0] v,
                                                   input int unsigned s);
        logic signed [RND_W-1:0] r;
        logic signed [RND_W-1:0] q;
        r = v + (RND_W'(1) << (s - 1));
        q = r >>> s;
        if ((&q[RND_W-1:OUT_W-1]) || !(|q[RND_W-1:OUT_W-1])) begin
            return q[OUT_W-1:0];
        end else if (q[RND_W-1]) begin
            return {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            return {1'b0, {(OUT_W-1){1'b1}}};
        end
    endfunction

endpackage

/* rtl/csrs3d_ram.sv */
// generic single-write, dual-read memory with registered read data
module csrs3d_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

/* rtl/csrs3d_scan.sv */
// raster position counters, interior test and window store addressing
module csrs3d_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [csrs3d_pkg::CXR_W-1:0] i_cells_x,
    input  logic [csrs3d_pkg::CXR_W-1:0] i_cells_y,
    input  logic [csrs3d_pkg::CZR_W-1:0] i_cells_z,
    output csrs3d_pkg::t_scan            o_scan
);
    import csrs3d_pkg::*;

    logic [COL_W-1:0] r_pos_x, n_pos_x;
    logic [ROW_W-1:0] r_pos_y, n_pos_y;
    logic [CZR_W-1:0] r_pos_z, n_pos_z;
    logic [1:0]       r_slot, n_slot;     // pos_z mod 3

    logic [DIMX_W-1:0] dim_x;
    logic [DIMY_W-1:0] dim_y;
    logic [CZR_W-1:0]  dim_z;
    logic [1:0]        slot_1;
    logic [1:0]        slot_0;
    logic [ROW_W-1:0]  row_p, row_j, row_m;
    logic [COL_W-1:0]  col_i, col_p, col_m;

    // grid size clamped to the supported range
    always_comb begin
        if (32'(i_cells_x) < MIN_DIM) begin
            dim_x = DIMX_W'(MIN_DIM);
        end else if (32'(i_cells_x) > MAX_CELLS_X) begin
            dim_x = DIMX_W'(MAX_CELLS_X);
        end else begin
            dim_x = DIMX_W'(i_cells_x);
        end
        if (32'(i_cells_y) < MIN_DIM) begin
            dim_y = DIMY_W'(MIN_DIM);
        end else if (32'(i_cells_y) > MAX_CELLS_Y) begin
            dim_y = DIMY_W'(MAX_CELLS_Y);
        end else begin
            dim_y = DIMY_W'(i_cells_y);
        end
        if (32'(i_cells_z) < MIN_DIM) begin
            dim_z = CZR_W'(MIN_DIM);
        end else begin
            dim_z = i_cells_z;
        end
    end

    // advance in raster order, wrapping at the end of the grid
    always_comb begin
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_pos_z = r_pos_z;
        n_slot  = r_slot;
        if (i_advance) begin
            if (32'(r_pos_x) + 1 >= 32'(dim_x)) begin
                n_pos_x = '0;
                if (32'(r_pos_y) + 1 >= 32'(dim_y)) begin
                    n_pos_y = '0;
                    if (32'(r_pos_z) + 1 >= 32'(dim_z)) begin
                        n_pos_z = '0;
                        n_slot  = 2'd0;
                    end else begin
                        n_pos_z = r_pos_z + 1'b1;
                        n_slot  = (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
                    end
                end else begin
                    n_pos_y = r_pos_y + 1'b1;
                end
            end else begin
                n_pos_x = r_pos_x + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pos_z <= '0;
            r_slot  <= 2'd0;
        end else begin
            r_pos_x <= n_pos_x;
            r_pos_y <= n_pos_y;
            r_pos_z <= n_pos_z;
            r_slot  <= n_slot;
        end
    end

    // slot_1 holds the previous plane, slot_0 the one before
    assign slot_1 = (r_slot == 2'd0) ? 2'd2 : r_slot - 2'd1;
    assign slot_0 = (r_slot == 2'd2) ? 2'd0 : r_slot + 2'd1;
    assign row_p  = r_pos_y;
    assign row_j  = r_pos_y - 1'b1;
    assign row_m  = r_pos_y - 2'd2;
    assign col_i  = r_pos_x;
    assign col_p  = r_pos_x + 1'b1;
    assign col_m  = r_pos_x - 1'b1;

    always_comb begin
        o_scan.hit = (r_pos_x != '0)
                   && (32'(r_pos_x) + 2 <= 32'(dim_x))
                   && (32'(r_pos_y) >= 2) && (32'(r_pos_y) + 1 <= 32'(dim_y))
                   && (32'(r_pos_z) >= 2) && (32'(r_pos_z) + 1 <= 32'(dim_z));
        o_scan.wr_addr = store_addr(r_slot, row_p, col_i);
        o_scan.col     = IDX_COL_W'(r_pos_x);
        o_scan.row     = IDX_ROW_W'(row_j);
        o_scan.plane   = r_pos_z - 1'b1;

        // x velocity faces
        o_scan.rd_addr[0][0] = store_addr(slot_1, row_j, col_p);
        o_scan.rd_addr[0][1] = store_addr(slot_1, row_j, col_i);
        o_scan.rd_addr[0][2] = store_addr(slot_1, row_p, col_i);
        o_scan.rd_addr[0][3] = store_addr(slot_1, row_p, col_p);
        o_scan.rd_addr[0][4] = store_addr(slot_1, row_m, col_i);
        o_scan.rd_addr[0][5] = store_addr(slot_1, row_m, col_p);
        o_scan.rd_addr[0][6] = store_addr(r_slot, row_j, col_i);
        o_scan.rd_addr[0][7] = store_addr(r_slot, row_j, col_p);
        o_scan.rd_addr[0][8] = store_addr(slot_0, row_j, col_i);
        o_scan.rd_addr[0][9] = store_addr(slot_0, row_j, col_p);
        // y velocity faces, last port spare
        o_scan.rd_addr[1][0] = store_addr(slot_1, row_p, col_i);
        o_scan.rd_addr[1][1] = store_addr(slot_1, row_j, col_i);
        o_scan.rd_addr[1][2] = store_addr(slot_1, row_j, col_p);
        o_scan.rd_addr[1][3] = store_addr(slot_1, row_p, col_p);
        o_scan.rd_addr[1][4] = store_addr(slot_1, row_j, col_m);
        o_scan.rd_addr[1][5] = store_addr(slot_1, row_p, col_m);
        o_scan.rd_addr[1][6] = store_addr(r_slot, row_j, col_i);
        o_scan.rd_addr[1][7] = store_addr(slot_0, row_j, col_i);
        o_scan.rd_addr[1][8] = store_addr(slot_0, row_p, col_i);
        o_scan.rd_addr[1][9] = store_addr(slot_1, row_p, col_i);
        // z velocity faces, last port spare
        o_scan.rd_addr[2][0] = store_addr(r_slot, row_j, col_i);
        o_scan.rd_addr[2][1] = store_addr(r_slot, row_j, col_p);
        o_scan.rd_addr[2][2] = store_addr(r_slot, row_j, col_m);
        o_scan.rd_addr[2][3] = store_addr(r_slot, row_m, col_i);
        o_scan.rd_addr[2][4] = store_addr(slot_1, row_j, col_i);
        o_scan.rd_addr[2][5] = store_addr(slot_1, row_p, col_i);
        o_scan.rd_addr[2][6] = store_addr(slot_1, row_m, col_i);
        o_scan.rd_addr[2][7] = store_addr(slot_1, row_j, col_p);
        o_scan.rd_addr[2][8] = store_addr(slot_1, row_j, col_m);
        o_scan.rd_addr[2][9] = store_addr(r_slot, row_j, col_i);
    end

endmodule

/* rtl/csrs3d_arith.sv */
// face sums, spacing products and round/saturate stages of the stencil
module csrs3d_arith (
    input  logic                                                             i_clk,
    input  csrs3d_pkg::t_pipe_en                                             i_en,
    input  logic [csrs3d_pkg::N_COMP-1:0][csrs3d_pkg::N_RD-1:0][csrs3d_pkg::VEL_W-1:0] i_rd,
    input  logic [csrs3d_pkg::VEL_W-1:0]                                     i_cur_y,
    input  logic [csrs3d_pkg::VEL_W-1:0]                                     i_cur_z,
    input  logic [csrs3d_pkg::IDX_COL_W-1:0]                                 i_col,
    input  logic [csrs3d_pkg::IDX_ROW_W-1:0]                                 i_row,
    input  logic [csrs3d_pkg::IDX_PLANE_W-1:0]                               i_plane,
    input  logic [csrs3d_pkg::INV_W-1:0]                                     i_inv_x,
    input  logic [csrs3d_pkg::INV_W-1:0]                                     i_inv_y,
    input  logic [csrs3d_pkg::INV_W-1:0]                                     i_inv_z,
    output csrs3d_pkg::t_result                                              o_result
);
    import csrs3d_pkg::*;

    logic signed [SUM_W-1:0]  r_sum  [N_TERM];
    logic signed [PROD_W-1:0] r_prod [N_TERM];
    logic signed [MUL_W-1:0]  inv_x, inv_y, inv_z;
    logic [IDX_COL_W-1:0]     r2_col, r3_col;
    logic [IDX_ROW_W-1:0]     r2_row, r3_row;
    logic [IDX_PLANE_W-1:0]   r2_plane, r3_plane;
    t_result                  r_result;

    assign inv_x = signed'({1'b0, i_inv_x});
    assign inv_y = signed'({1'b0, i_inv_y});
    assign inv_z = signed'({1'b0, i_inv_z});

    // differences and four-face sums
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_sum[0] <= sx(i_rd[0][0]) - sx(i_rd[0][1]);
            r_sum[1] <= sx(i_rd[1][0]) - sx(i_rd[1][1]);
            r_sum[2] <= sx(i_rd[2][0]) - sx(i_rd[2][4]);
            r_sum[3] <= sx(i_rd[1][6]) + sx(i_cur_y) - sx(i_rd[1][7]) - sx(i_rd[1][8]);
            r_sum[4] <= sx(i_rd[2][5]) + sx(i_cur_z) - sx(i_rd[2][6]) - sx(i_rd[2][3]);
            r_sum[5] <= sx(i_rd[0][6]) + sx(i_rd[0][7]) - sx(i_rd[0][8]) - sx(i_rd[0][9]);
            r_sum[6] <= sx(i_rd[2][7]) + sx(i_rd[2][1]) - sx(i_rd[2][8]) - sx(i_rd[2][2]);
            r_sum[7] <= sx(i_rd[0][2]) + sx(i_rd[0][3]) - sx(i_rd[0][4]) - sx(i_rd[0][5]);
            r_sum[8] <= sx(i_rd[1][2]) + sx(i_rd[1][3]) - sx(i_rd[1][4]) - sx(i_rd[1][5]);
            r2_col   <= i_col;
            r2_row   <= i_row;
            r2_plane <= i_plane;
        end
    end

    // one product per term
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_prod[0] <= r_sum[0] * inv_x;
            r_prod[1] <= r_sum[1] * inv_y;
            r_prod[2] <= r_sum[2] * inv_z;
            r_prod[3] <= r_sum[3] * inv_z;
            r_prod[4] <= r_sum[4] * inv_y;
            r_prod[5] <= r_sum[5] * inv_z;
            r_prod[6] <= r_sum[6] * inv_x;
            r_prod[7] <= r_sum[7] * inv_y;
            r_prod[8] <= r_sum[8] * inv_x;
            r3_col    <= r2_col;
            r3_row    <= r2_row;
            r3_plane  <= r2_plane;
        end
    end

    // off-diagonal pair sums, rounding and saturation into the result register
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_result.strain_xx <= round_sat(RND_W'(r_prod[0]), FRAC_BITS);
            r_result.strain_yy <= round_sat(RND_W'(r_prod[1]), FRAC_BITS);
            r_result.strain_zz <= round_sat(RND_W'(r_prod[2]), FRAC_BITS);
            r_result.strain_yz <= round_sat(RND_W'(r_prod[3]) + RND_W'(r_prod[4]),
                                            FRAC_BITS + OFFDIAG_SHIFT);
            r_result.strain_xz <= round_sat(RND_W'(r_prod[5]) + RND_W'(r_prod[6]),
                                            FRAC_BITS + OFFDIAG_SHIFT);
            r_result.strain_xy <= round_sat(RND_W'(r_prod[7]) + RND_W'(r_prod[8]),
                                            FRAC_BITS + OFFDIAG_SHIFT);
            r_result.cell_col   <= r3_col;
            r_result.cell_row   <= r3_row;
            r_result.cell_plane <= r3_plane;
        end
    end

    assign o_result = r_result;

endmodule

/* rtl/cell_strain_rate_stencil_3d_unit.sv */
// top level of the 3d staggered-grid strain-rate stencil
// throughput: one cell item per cycle while the output is not stalled, set by the dual-port
// window memories (one write, two reads)
// the four stages (memory read, face sums, products, round/saturate) each advance when downstream
// has room, so input is taken while a finished result waits at the output if a stage is empty
// reset: position returns to cell (0,0,0), spacings to 1.0, sizes to 128; the store is not cleared
module cell_strain_rate_stencil_3d_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write port
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [23:0]  i_cfg_data,
    // cell items in
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // vel_x_lower, vel_y_lower, vel_z_lower
    // result items out
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [223:0] m_axis_tdata    // strain_xx, strain_yy, strain_zz, strain_yz,
                                         // strain_xz, strain_xy, cell_col, cell_row,
                                         // cell_plane, zero pad
);
    import csrs3d_pkg::*;

    // configuration registers
    logic [INV_W-1:0] r_inv_x, r_inv_y, r_inv_z;
    logic [CXR_W-1:0] r_cells_x, r_cells_y;
    logic [CZR_W-1:0] r_cells_z;

    // pipeline occupancy, one flag per stage
    logic r_v1, r_v2, r_v3, r_v4;
    logic en1;
    logic accept;
    t_pipe_en en;

    t_scan   scan;
    t_result result;

    logic [N_COMP-1:0][VEL_W-1:0]           vel;
    logic [N_COMP-1:0][N_RD-1:0][VEL_W-1:0] rd;

    // stage one payload next to the memory read data: the current cell bypasses the store
    logic [VEL_W-1:0]       r1_cur_y, r1_cur_z;
    logic [IDX_COL_W-1:0]   r1_col;
    logic [IDX_ROW_W-1:0]   r1_row;
    logic [IDX_PLANE_W-1:0] r1_plane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_x   <= INV_W'(1 << FRAC_BITS);
            r_inv_y   <= INV_W'(1 << FRAC_BITS);
            r_inv_z   <= INV_W'(1 << FRAC_BITS);
            r_cells_x <= CXR_W'(MAX_CELLS_X);
            r_cells_y <= CXR_W'(MAX_CELLS_Y);
            r_cells_z <= CZR_W'(128);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_INV_X:   r_inv_x   <= i_cfg_data[INV_W-1:0];
                CFG_INV_Y:   r_inv_y   <= i_cfg_data[INV_W-1:0];
                CFG_INV_Z:   r_inv_z   <= i_cfg_data[INV_W-1:0];
                CFG_CELLS_X: r_cells_x <= i_cfg_data[CXR_W-1:0];
                CFG_CELLS_Y: r_cells_y <= i_cfg_data[CXR_W-1:0];
                CFG_CELLS_Z: r_cells_z <= i_cfg_data[CZR_W-1:0];
                default: ;   // unused indexes ignore the write
            endcase
        end
    end

    // each stage moves when it is empty or the one after it moves
    assign en.s4   = !r_v4 || m_axis_tready;
    assign en.s3   = !r_v3 || en.s4;
    assign en.s2   = !r_v2 || en.s3;
    assign en1     = !r_v1 || en.s2;
    assign accept  = s_axis_tvalid && en1;
    assign s_axis_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept && scan.hit;   // boundary cells only fill the store
            end
            if (en.s2) begin
                r_v2 <= r_v1;
            end
            if (en.s3) begin
                r_v3 <= r_v2;
            end
            if (en.s4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign vel = s_axis_tdata[N_COMP*VEL_W-1:0];

    csrs3d_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_cells_x (r_cells_x),
        .i_cells_y (r_cells_y),
        .i_cells_z (r_cells_z),
        .o_scan    (scan)
    );

    // window store: per velocity component, copies that share the write and split the reads
    for (genvar c = 0; c < N_COMP; c++) begin : g_comp
        for (genvar k = 0; k < N_PAIR; k++) begin : g_pair
            csrs3d_ram #(
                .WIDTH (VEL_W),
                .DEPTH (STORE_DEPTH)
            ) u_ram (
                .i_clk       (i_clk),
                .i_we        (accept),
                .i_wr_addr   (scan.wr_addr),
                .i_wr_data   (vel[c]),
                .i_re        (accept),
                .i_rd_addr_a (scan.rd_addr[c][2*k]),
                .i_rd_addr_b (scan.rd_addr[c][2*k+1]),
                .o_rd_data_a (rd[c][2*k]),
                .o_rd_data_b (rd[c][2*k+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r1_cur_y <= vel[1];
            r1_cur_z <= vel[2];
            r1_col   <= scan.col;
            r1_row   <= scan.row;
            r1_plane <= scan.plane;
        end
    end

    csrs3d_arith u_arith (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_rd     (rd),
        .i_cur_y  (r1_cur_y),
        .i_cur_z  (r1_cur_z),
        .i_col    (r1_col),
        .i_row    (r1_row),
        .i_plane  (r1_plane),
        .i_inv_x  (r_inv_x),
        .i_inv_y  (r_inv_y),
        .i_inv_z  (r_inv_z),
        .o_result (result)
    );

    assign m_axis_tvalid = r_v4;
    assign m_axis_tdata  = {{(224 - $bits(t_result)){1'b0}}, result};

endmodule

/* tb/testbench.sv */
// self-checking testbench for the 3d staggered-grid strain-rate stencil
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import csrs3d_pkg::*;

    localparam int PLANE   = 128 * 128;
    localparam int DEPTH   = 3 * PLANE;
    localparam int LIMIT   = 5000;   // cycles with no item moving on either side
    localparam int SETTLE  = 8;      // cycles for cells still inside the pipeline

    // one expected strain-rate result
    typedef struct {
        logic [31:0] strain [6];
        logic [6:0]  col;
        logic [6:0]  row;
        logic [15:0] plane;
    } strain_t;

    // tracks the grid position and the face window, predicts each result
    class strain_board;
        logic signed [23:0] faces [DEPTH][3];
        int unsigned px, py, pz;
        longint unsigned inv [3];
        int unsigned dim [3];
        strain_t pending [$];
        int errors;

        function new();
            foreach (faces[i, c]) faces[i][c] = '0;
            px = 0; py = 0; pz = 0;
            inv = '{4096, 4096, 4096};
            dim = '{128, 128, 128};
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [23:0] v);
            case (idx)
                CFG_INV_X:   inv[0] = 64'(v);
                CFG_INV_Y:   inv[1] = 64'(v);
                CFG_INV_Z:   inv[2] = 64'(v);
                CFG_CELLS_X: dim[0] = 32'(v[7:0]);
                CFG_CELLS_Y: dim[1] = 32'(v[7:0]);
                CFG_CELLS_Z: dim[2] = 32'(v[15:0]);
                default: ;
            endcase
        endfunction

        function longint fv(int c, int unsigned p, int unsigned r, int unsigned k);
            return longint'(faces[(p * PLANE + r * 128 + k) % DEPTH][c]);
        endfunction

        // nearest, ties up, then clip to 32 bits signed
        function logic [31:0] rnd_clip(longint v, int s);
            longint r;
            r = (v + (longint'(1) << (s - 1))) >>> s;
            if (r > 64'sd2147483647) r = 64'sd2147483647;
            if (r < -64'sd2147483648) r = -64'sd2147483648;
            return r[31:0];
        endfunction

        // accepted cell: write its faces, predict, advance the raster position
        function void note_cell(logic [71:0] d);
            int unsigned cx, cy, cz, x, y, z, p0, p1, p2, i, im, ip, j, jm, jp;
            longint ix, iy, iz, sa, sb;
            strain_t e;
            cx = dim[0] < 3 ? 3 : (dim[0] > 128 ? 128 : dim[0]);
            cy = dim[1] < 3 ? 3 : (dim[1] > 128 ? 128 : dim[1]);
            cz = dim[2] < 3 ? 3 : dim[2];
            x = px; y = py; z = pz;
            p2 = z % 3; p1 = (z + 2) % 3; p0 = (z + 1) % 3;
            for (int c = 0; c < 3; c++)
                faces[(p2 * PLANE + y * 128 + x) % DEPTH][c] = d[24*c +: 24];
            if (x >= 1 && x + 2 <= cx && y >= 2 && y + 1 <= cy && z >= 2 && z + 1 <= cz) begin
                ix = inv[0]; iy = inv[1]; iz = inv[2];
                i = x; im = x - 1; ip = x + 1;
                j = y - 1; jm = y - 2; jp = y;
                e.strain[0] = rnd_clip((fv(0, p1, j, ip) - fv(0, p1, j, i)) * ix, 12);
                e.strain[1] = rnd_clip((fv(1, p1, jp, i) - fv(1, p1, j, i)) * iy, 12);
                e.strain[2] = rnd_clip((fv(2, p2, j, i) - fv(2, p1, j, i)) * iz, 12);
                sa = fv(1, p2, j, i) + fv(1, p2, jp, i) - fv(1, p0, j, i) - fv(1, p0, jp, i);
                sb = fv(2, p1, jp, i) + fv(2, p2, jp, i) - fv(2, p1, jm, i) - fv(2, p2, jm, i);
                e.strain[3] = rnd_clip(sa * iz + sb * iy, 15);
                sa = fv(0, p2, j, i) + fv(0, p2, j, ip) - fv(0, p0, j, i) - fv(0, p0, j, ip);
                sb = fv(2, p1, j, ip) + fv(2, p2, j, ip) - fv(2, p1, j, im) - fv(2, p2, j, im);
                e.strain[4] = rnd_clip(sa * iz + sb * ix, 15);
                sa = fv(0, p1, jp, i) + fv(0, p1, jp, ip) - fv(0, p1, jm, i) - fv(0, p1, jm, ip);
                sb = fv(1, p1, j, ip) + fv(1, p1, jp, ip) - fv(1, p1, j, im) - fv(1, p1, jp, im);
                e.strain[5] = rnd_clip(sa * iy + sb * ix, 15);
                e.col = 7'(x); e.row = 7'(y - 1); e.plane = 16'(z - 1);
                pending.push_back(e);
            end
            if (x + 1 >= cx) begin
                px = 0;
                if (y + 1 >= cy) begin
                    py = 0;
                    pz = (z + 1 >= cz) ? 0 : z + 1;
                end else begin
                    py = y + 1;
                end
            end else begin
                px = x + 1;
            end
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endfunction

        function void check_result(logic [223:0] d);
            strain_t e;
            string names [6];
            names = '{"strain_xx", "strain_yy", "strain_zz", "strain_yz", "strain_xz",
                      "strain_xy"};
            if (pending.size() == 0) begin
                report("unexpected result", d[31:0], 32'h0);
                return;
            end
            e = pending.pop_front();
            for (int k = 0; k < 6; k++)
                if (d[32*k +: 32] !== e.strain[k]) report(names[k], d[32*k +: 32], e.strain[k]);
            if (d[198:192] !== e.col)   report("cell_col", 32'(d[198:192]), 32'(e.col));
            if (d[205:199] !== e.row)   report("cell_row", 32'(d[205:199]), 32'(e.row));
            if (d[221:206] !== e.plane) report("cell_plane", 32'(d[221:206]), 32'(e.plane));
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_index = '0;
    logic [23:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata = '0;    // vel_x_lower, vel_y_lower, vel_z_lower
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [223:0] m_axis_tdata;         // strain xx yy zz yz xz xy, col, row, plane, pad

    strain_board board = new();
    bit  calm = 1'b0;                   // no idling on either side
    int  quiet_cycles = 0;
    int  stall_left = 0;
    int  n_sent = 0;                    // cell items accepted so far

    always #1 i_clk = ~i_clk;

    cell_strain_rate_stencil_3d_unit dut (.*);

    // receiver: random stall bursts, always ready once calm
    always @(posedge i_clk) begin
        if (calm) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(1, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= LIMIT) begin
            $display("[cell_strain_rate_stencil_3d_unit] ERROR");
            $finish;
        end
    end

    task automatic write_reg(t_cfg_idx idx, logic [23:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        board.set_reg(idx, v);
    endtask

    // block idle: every result in, then the pipeline flushed of no-result cells
    task automatic settle();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // velocity: half the time random, otherwise an extreme or a small value
    function automatic logic [23:0] pick_vel();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 200)) - 100);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_inv();
        case ($urandom_range(0, 4))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'd4096;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_cell(logic [71:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_cell(d);
        n_sent++;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int n);
        for (int k = 0; k < n; k++) send_cell({pick_vel(), pick_vel(), pick_vel()});
    endtask

    // keep streaming until the raster position is back at the first cell
    task automatic finish_grid();
        while (board.px != 0 || board.py != 0 || board.pz != 0)
            send_cell({pick_vel(), pick_vel(), pick_vel()});
        s_axis_tvalid <= 1'b0;
        settle();
    endtask

    task automatic set_grid(logic [23:0] ix, logic [23:0] iy, logic [23:0] iz,
                            logic [23:0] cx, logic [23:0] cy, logic [23:0] cz);
        write_reg(CFG_INV_X, ix);
        write_reg(CFG_INV_Y, iy);
        write_reg(CFG_INV_Z, iz);
        write_reg(CFG_CELLS_X, cx);
        write_reg(CFG_CELLS_Y, cy);
        write_reg(CFG_CELLS_Z, cz);
    endtask

    initial begin
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: smallest grid, alternating extreme faces drive saturation
        set_grid(24'hFFFFFF, 24'h0, 24'd4096, 24'd3, 24'd3, 24'd3);
        for (int k = 0; k < 27; k++) begin
            if (k % 2 == 0)
                send_cell({24'h7FFFFF, 24'h800000, 24'h7FFFFF});
            else
                send_cell({24'h800000, 24'h7FFFFF, 24'h800000});
        end
        s_axis_tvalid <= 1'b0;
        settle();

        // register indexes past the last one are ignored
        i_cfg_we <= 1'b1;
        i_cfg_index <= 3'd6;
        i_cfg_data <= 24'h000001;
        @(posedge i_clk);
        i_cfg_index <= 3'd7;
        i_cfg_data <= 24'hFFFFFF;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;

        // sizes below the minimum clamp to three; many random small grids
        set_grid(24'd4096, 24'hFFFFFF, 24'h0, 24'd0, 24'd1, 24'd2);
        finish_grid();
        send_random(27);
        finish_grid();
        while (n_sent < 280) begin
            set_grid(pick_inv(), pick_inv(), pick_inv(), 24'($urandom_range(3, 10)),
                     24'($urandom_range(3, 6)), 24'($urandom_range(3, 5)));
            n = $urandom_range(20, 60);
            send_random(n);
            finish_grid();
        end

        // deepest plane count, then a size cut while the stream is mid-way
        set_grid(pick_inv(), pick_inv(), pick_inv(), 24'd3, 24'd3, 24'd65535);
        send_random(36);
        s_axis_tvalid <= 1'b0;
        settle();
        write_reg(CFG_CELLS_Z, 24'd3);
        finish_grid();

        // widest rows (over-range clamps to the maximum), then the width drops mid-row
        calm = 1'b1;
        set_grid(pick_inv(), pick_inv(), pick_inv(), 24'd255, 24'd3, 24'd3);
        send_random(130);
        s_axis_tvalid <= 1'b0;
        settle();
        write_reg(CFG_CELLS_X, 24'd3);
        finish_grid();

        if (board.errors == 0) begin
            $display("[cell_strain_rate_stencil_3d_unit] OK");
        end else begin
            $display("[cell_strain_rate_stencil_3d_unit] ERROR");
        end
        $finish;
    end
endmodule
